### rtl/pli_pkg.sv
package pli_pkg;

	localparam int CAPACITY = 64;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_BAD_POS = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] slot;
	} cell_ctl_t;

endpackage

### rtl/pli_req_if.sv
interface pli_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      cmd;
	logic [pli_pkg::POS_W-1:0]       position;
	logic signed [pli_pkg::WORD_W-1:0] value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink   (input valid, cmd, position, value, output ready);
endinterface

### rtl/pli_rsp_if.sv
interface pli_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic signed [pli_pkg::WORD_W-1:0] removed_value;
	logic [pli_pkg::COUNT_W-1:0]       entry_count;

	modport source (output valid, status, removed_value, entry_count, input ready);
	modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

### rtl/pli_cell.sv
module pli_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  pli_pkg::cell_ctl_t          ctl,
	input  logic [pli_pkg::WORD_W-1:0]  value,
	input  logic [pli_pkg::WORD_W-1:0]  left,
	input  logic [pli_pkg::WORD_W-1:0]  right,
	output logic [pli_pkg::WORD_W-1:0]  word,
	output logic [pli_pkg::WORD_W-1:0]  tap
);

	localparam logic [31:0] IDX_V = 32'(IDX);

	logic [pli_pkg::WORD_W-1:0] word_q;
	logic [pli_pkg::WORD_W-1:0] tap_q;
	logic [31:0]                slot_v;
	logic                       at_slot;
	logic                       past_slot;

	assign slot_v    = 32'(ctl.slot);
	assign at_slot   = IDX_V == slot_v;
	assign past_slot = IDX_V > slot_v;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			pli_pkg::OP_INSERT: begin
				if (at_slot) begin
					word_q <= value;
				end else if (past_slot) begin
					word_q <= left;
				end
			end
			pli_pkg::OP_DELETE: begin
				if (at_slot || past_slot) begin
					word_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.op != pli_pkg::OP_HOLD) begin
			tap_q <= (ctl.op == pli_pkg::OP_DELETE && at_slot) ? word_q : '0;
		end
	end

	assign word = word_q;
	assign tap  = tap_q;

endmodule

### rtl/pli_or_tree.sv
module pli_or_tree #(
	parameter int N      = pli_pkg::CAPACITY,
	parameter int LEVELS = (($clog2(pli_pkg::CAPACITY) + 1) / 2)
) (
	input  logic                               clk,
	input  logic [N-1:0][pli_pkg::WORD_W-1:0]  taps,
	output logic [pli_pkg::WORD_W-1:0]         root
);

	localparam int PAD  = 1 << (2 * LEVELS);
	localparam int INTN = (PAD - 1) / 3;

	logic [pli_pkg::WORD_W-1:0] leaf   [PAD];
	logic [pli_pkg::WORD_W-1:0] node_q [INTN];
	logic [pli_pkg::WORD_W-1:0] kid    [INTN][4];

	for (genvar j = 0; j < PAD; j++) begin : g_leaf
		if (j < N) begin : g_real
			assign leaf[j] = taps[j];
		end else begin : g_pad
			assign leaf[j] = '0;
		end
	end

	for (genvar k = 0; k < INTN; k++) begin : g_node
		for (genvar c = 0; c < 4; c++) begin : g_kid
			if (4 * k + 1 + c < INTN) begin : g_inner
				assign kid[k][c] = node_q[4 * k + 1 + c];
			end else begin : g_outer
				assign kid[k][c] = leaf[4 * k + 1 + c - INTN];
			end
		end
		always_ff @(posedge clk) begin
			node_q[k] <= kid[k][0] | kid[k][1] | kid[k][2] | kid[k][3];
		end
	end

	assign root = node_q[0];

endmodule

### rtl/positional_list_insert_delete_top.sv
// Channel  Dir  Fields                                   Transaction
// req      in   cmd[1:0] position[6:0] value[31:0]       valid && ready
// rsp      out  status[1:0] removed_value[31:0]          valid && ready
//               entry_count[6:0]
//
// One command at a time; the result register is loaded once the registered
// radix-4 tree has gathered the removed word from the cell row; the tree has
// LEVELS = ceil(log2(CAPACITY)/2) register levels.
// Cells at and past the position shift in the cycle an insert or delete is accepted.
// A result waits in the output register while req is accepted again.
// Reset clears the count and control; stored words need no reset.
module positional_list_insert_delete_top #(
	parameter int CAPACITY = pli_pkg::CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	pli_req_if.sink   req,
	pli_rsp_if.source rsp
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int CMPW   = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 1;
	localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
	localparam int WCW    = $clog2(LEVELS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WAIT = 2'b10
	} state_t;

	state_t                     state_q;
	logic [WCW-1:0]             wait_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              count_n;
	logic                       out_valid_q;

	logic [1:0]                 res_status_q;
	logic                       res_tree_q;
	logic [pli_pkg::WORD_W-1:0] res_const_q;

	logic [1:0]                 out_status_q;
	logic [pli_pkg::WORD_W-1:0] out_removed_q;
	logic [pli_pkg::COUNT_W-1:0] out_count_q;

	logic                       accept;
	logic                       load;
	logic [CMPW-1:0]            pos_e;
	logic [CMPW-1:0]            cnt_e;
	logic                       ins_bad;
	logic                       ins_ok;
	logic                       full;
	logic                       del_bad;
	pli_pkg::cell_ctl_t         ctl;
	logic [1:0]                 status_n;
	logic                       use_tree_n;
	logic [pli_pkg::WORD_W-1:0] const_n;
	logic [pli_pkg::WORD_W-1:0] root;

	logic [CAPACITY-1:0][pli_pkg::WORD_W-1:0] words;
	logic [CAPACITY-1:0][pli_pkg::WORD_W-1:0] taps;

	assign accept  = req.valid && req.ready;
	assign req.ready = state_q == ST_IDLE;
	assign load    = state_q == ST_WAIT && wait_q == '0 && (!out_valid_q || rsp.ready);

	assign pos_e   = CMPW'(req.position);
	assign cnt_e   = CMPW'(count_q);
	assign ins_bad = pos_e == '0 || pos_e > cnt_e + CMPW'(1);
	assign full    = count_q == CW'(CAPACITY);
	assign ins_ok  = !ins_bad && !full;
	assign del_bad = pos_e == '0 || pos_e > cnt_e;

	always_comb begin
		ctl.op     = pli_pkg::OP_HOLD;
		ctl.slot   = req.position - pli_pkg::POS_W'(1);
		status_n   = pli_pkg::STATUS_BAD_POS;
		use_tree_n = 1'b0;
		const_n    = '0;
		count_n    = count_q;
		if (accept) begin
			unique case (req.cmd)
				pli_pkg::CMD_INSERT: begin
					if (ins_bad) begin
						status_n = pli_pkg::STATUS_BAD_POS;
					end else if (full) begin
						status_n = pli_pkg::STATUS_FULL;
					end else begin
						ctl.op   = pli_pkg::OP_INSERT;
						status_n = pli_pkg::STATUS_OK;
						count_n  = count_q + CW'(1);
					end
				end
				pli_pkg::CMD_DELETE: begin
					if (del_bad) begin
						const_n = '1;
					end else begin
						ctl.op     = pli_pkg::OP_DELETE;
						status_n   = pli_pkg::STATUS_OK;
						use_tree_n = 1'b1;
						count_n    = count_q - CW'(1);
					end
				end
				pli_pkg::CMD_CLEAR: begin
					status_n = pli_pkg::STATUS_OK;
					count_n  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [pli_pkg::WORD_W-1:0] left;
		logic [pli_pkg::WORD_W-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = words[i+1];
		end
		pli_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.value(req.value),
			.left (left),
			.right(right),
			.word (words[i]),
			.tap  (taps[i])
		);
	end

	pli_or_tree #(
		.N     (CAPACITY),
		.LEVELS(LEVELS)
	) u_tree (
		.clk (clk),
		.taps(taps),
		.root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_n;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WAIT;
						wait_q  <= WCW'(LEVELS);
					end
				end
				ST_WAIT: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - WCW'(1);
					end else if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= status_n;
			res_tree_q   <= use_tree_n;
			res_const_q  <= const_n;
		end
		if (load) begin
			out_status_q  <= res_status_q;
			out_removed_q <= res_tree_q ? root : res_const_q;
			out_count_q   <= pli_pkg::COUNT_W'(count_q);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.removed_value = out_removed_q;
	assign rsp.entry_count   = out_count_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_accept_wait: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_WAIT)
		else $error("accepted command did not start the wait");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == pli_pkg::CMD_INSERT && ins_ok)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> out_count_q == pli_pkg::COUNT_W'(count_q))
		else $error("result count does not match list count");

endmodule
